// File: hw/rtl/two_channel_pid_with_clamped_integral_macros.svh
// Assertion macros shared by the PID block.
`ifndef TWO_CHANNEL_PID_WITH_CLAMPED_INTEGRAL_MACROS_SVH
`define TWO_CHANNEL_PID_WITH_CLAMPED_INTEGRAL_MACROS_SVH
`define PID_ASSERT_IMP(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
else $error("assertion failed");
`define PID_ASSERT_NXT(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
else $error("assertion failed");
`endif

// File: hw/rtl/tcpid_pkg.sv
`default_nettype none
package tcpid_pkg;
	localparam int unsigned ErrRecip = 83887;
	localparam int unsigned ErrShift = 23;

	localparam logic [2:0] RegGainPHigh = 3'd0;
	localparam logic [2:0] RegGainIHigh = 3'd1;
	localparam logic [2:0] RegGainDHigh = 3'd2;
	localparam logic [2:0] RegGainPLow = 3'd3;
	localparam logic [2:0] RegGainILow = 3'd4;
	localparam logic [2:0] RegGainDLow = 3'd5;
	localparam logic [2:0] RegDriveLimit = 3'd6;
	localparam logic [2:0] RegTimeStep = 3'd7;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ERR_DIV,
		CMD_DER_DIV,
		CMD_MUL_P,
		CMD_MUL_I,
		CMD_MUL_D,
		CMD_SUM_INT,
		CMD_CLAMP_DIV,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic div_start;
	} ctrl_t;

	typedef struct packed {
		logic div_busy;
		logic gi_zero;
	} stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/two_channel_pid_with_clamped_integral.sv
// An accepted word runs through two serial divisions (error change by time step, integral
// bound), the second skipped when the integral gain is zero, while the error division by
// 100 is a reciprocal multiply. The block takes no new word until the last one is done,
// and a held result stalls the next input. Reset: asynchronous, active low; gains clear,
// drive limit 12000, time step 655, integrals and previous errors clear.
`default_nettype none
module two_channel_pid_with_clamped_integral #(
	parameter int unsigned CHANNELS = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               link_select,
	input  wire logic signed [15:0] target_position,
	input  wire logic signed [15:0] measured_position,
	input  wire logic               clear_integral,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      drive,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	logic [15:0] gain_q [6];
	logic [14:0] limit_q;
	logic [15:0] step_q;
	tcpid_pkg::ctrl_t ctrl;
	tcpid_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) gain_q[i] <= '0;
			limit_q <= 15'd12000;
			step_q <= 16'd655;
		end else if (cfg_valid) begin
			if (cfg_index == tcpid_pkg::RegDriveLimit) limit_q <= cfg_data[14:0];
			else if (cfg_index == tcpid_pkg::RegTimeStep) step_q <= cfg_data;
			else gain_q[cfg_index] <= cfg_data;
		end
	end

	tcpid_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
	);

	tcpid_dp #(.CHANNELS(CHANNELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.link_select(link_select), .target_position(target_position),
		.measured_position(measured_position), .clear_integral(clear_integral),
		.gain_p(link_select ? gain_q[tcpid_pkg::RegGainPLow] : gain_q[tcpid_pkg::RegGainPHigh]),
		.gain_i(link_select ? gain_q[tcpid_pkg::RegGainILow] : gain_q[tcpid_pkg::RegGainIHigh]),
		.gain_d(link_select ? gain_q[tcpid_pkg::RegGainDLow] : gain_q[tcpid_pkg::RegGainDHigh]),
		.drive_limit(limit_q), .time_step(step_q), .drive(drive)
	);
endmodule
`default_nettype wire

// File: hw/rtl/tcpid_div.sv
`default_nettype none
// Restoring divider on magnitudes, one quotient bit per cycle.
module tcpid_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [23:0] divisor,
	output logic             busy,
	output logic [47:0]      quotient
);
	logic [5:0]  cnt_q;
	logic [23:0] rem_q;
	logic [47:0] quo_q;
	logic [23:0] dvs_q;
	logic [24:0] trial;

	assign trial = {rem_q, quo_q[47]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/tcpid_dp.sv
`default_nettype none
module tcpid_dp #(
	parameter int unsigned CHANNELS = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tcpid_pkg::ctrl_t   ctrl,
	output tcpid_pkg::stat_t        stat,
	input  wire logic               link_select,
	input  wire logic signed [15:0] target_position,
	input  wire logic signed [15:0] measured_position,
	input  wire logic               clear_integral,
	input  wire logic [15:0]        gain_p,
	input  wire logic [15:0]        gain_i,
	input  wire logic [15:0]        gain_d,
	input  wire logic [14:0]        drive_limit,
	input  wire logic [15:0]        time_step,
	output logic signed [15:0]      drive
);
	localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic signed [31:0] integ_q [CHANNELS];
	logic signed [15:0] last_q [CHANNELS];
	logic [ChW-1:0]     ch_q;
	logic signed [16:0] diff_q;
	logic signed [15:0] err_q;
	logic signed [15:0] der_q;
	logic signed [31:0] sum_q;
	logic signed [15:0] gp_q, gi_q, gd_q;
	logic signed [47:0] acc_q;
	logic signed [15:0] mop_a;
	logic signed [31:0] mop_b;
	logic signed [47:0] prod;
	logic [47:0]        dvd;
	logic [23:0]        dvs;
	logic               neg;
	logic               neg_q;
	logic               div_busy;
	logic [47:0]        quo;
	logic signed [48:0] qs;
	logic signed [17:0] dd;
	logic [15:0]        ts_eff;
	logic signed [48:0] nsum_full;
	logic signed [48:0] nsum_q;
	logic signed [47:0] dv;
	logic signed [47:0] lim48;
	logic signed [48:0] maxs;
	logic signed [48:0] ns;
	logic [15:0]        gi_mag;
	logic [ChW-1:0]     ch_d;
	logic [16:0]        dmag;
	logic [33:0]        eprod;
	logic [15:0]        emag;

	assign ts_eff = (time_step == 16'd0) ? 16'd1 : time_step;
	assign dd = 18'(err_q) - 18'(last_q[ch_q]);
	assign gi_mag = gi_q[15] ? 16'(-gi_q) : gi_q;
	assign ch_d = (32'(link_select) < CHANNELS) ? ChW'(link_select) : ChW'(CHANNELS - 1);

	assign dmag = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
	assign eprod = 34'(dmag) * 34'(tcpid_pkg::ErrRecip);
	assign emag = 16'(eprod >> tcpid_pkg::ErrShift);

	always_comb begin
		dvd = '0;
		dvs = 24'd1;
		neg = 1'b0;
		case (ctrl.cmd)
			tcpid_pkg::CMD_DER_DIV: begin
				neg = dd[17];
				dvd = {14'd0, 18'(dd[17] ? -dd : dd), 16'd0};
				dvs = 24'(ts_eff);
			end
			tcpid_pkg::CMD_CLAMP_DIV: begin
				dvd = {25'd0, drive_limit, 8'd0};
				dvs = 24'(gi_mag);
			end
			default: begin
			end
		endcase
	end

	tcpid_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctrl.div_start),
		.dividend(dvd), .divisor(dvs), .busy(div_busy), .quotient(quo)
	);

	always_comb begin
		mop_a = gp_q;
		mop_b = 32'(err_q);
		case (ctrl.cmd)
			tcpid_pkg::CMD_MUL_I: begin
				mop_a = gi_q;
				mop_b = sum_q;
			end
			tcpid_pkg::CMD_MUL_D: begin
				mop_a = gd_q;
				mop_b = 32'(der_q);
			end
			default: begin
			end
		endcase
	end
	assign prod = 48'(mop_a) * 48'(mop_b);

	assign qs = neg_q ? -49'(quo) : 49'(quo);
	assign nsum_full = (49'(sum_q) <<< 16) + 49'(err_q) * 49'($signed({1'b0, ts_eff}));
	assign lim48 = 48'($signed({1'b0, drive_limit}));
	assign dv = (acc_q < 0) ? -((-acc_q) >>> 8) : (acc_q >>> 8);
	assign maxs = 49'(quo);
	assign ns = nsum_q;

	assign stat.div_busy = div_busy;
	assign stat.gi_zero = (gi_q == 16'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				integ_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else begin
			case (ctrl.cmd)
				tcpid_pkg::CMD_LOAD: begin
					if (clear_integral) begin
						integ_q[ch_d] <= '0;
					end
				end
				tcpid_pkg::CMD_FINISH: begin
					if (stat.gi_zero) begin
						integ_q[ch_q] <= (nsum_q > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF :
							(nsum_q < -49'sh80000000) ? 32'sh80000000 : nsum_q[31:0];
					end else if (ns > maxs) begin
						integ_q[ch_q] <= 32'(maxs);
					end else if (ns < -maxs) begin
						integ_q[ch_q] <= 32'(-maxs);
					end else begin
						integ_q[ch_q] <= nsum_q[31:0];
					end
					last_q[ch_q] <= err_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			neg_q <= neg;
		end
		case (ctrl.cmd)
			tcpid_pkg::CMD_LOAD: begin
				ch_q <= ch_d;
				diff_q <= 17'(target_position) - 17'(measured_position);
				sum_q <= clear_integral ? 32'sd0 : integ_q[ch_d];
				gp_q <= gain_p;
				gi_q <= gain_i;
				gd_q <= gain_d;
			end
			tcpid_pkg::CMD_ERR_DIV: begin
				err_q <= diff_q[16] ? 16'(-emag) : emag;
			end
			tcpid_pkg::CMD_MUL_P: begin
				der_q <= (qs > 49'sd32767) ? 16'sh7FFF :
					(qs < -49'sd32768) ? 16'sh8000 : qs[15:0];
				acc_q <= prod;
				nsum_q <= (nsum_full < 0) ? -((-nsum_full) >>> 16) : (nsum_full >>> 16);
			end
			tcpid_pkg::CMD_MUL_I: begin
				acc_q <= acc_q + prod;
			end
			tcpid_pkg::CMD_MUL_D: begin
				acc_q <= acc_q + prod;
			end
			tcpid_pkg::CMD_SUM_INT: begin
				drive <= (dv > lim48) ? 16'(lim48) : (dv < -lim48) ? 16'(-lim48) : dv[15:0];
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/tcpid_ctrl.sv
`default_nettype none
`include "two_channel_pid_with_clamped_integral_macros.svh"
module tcpid_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire tcpid_pkg::stat_t stat,
	output tcpid_pkg::ctrl_t      ctrl
);
	typedef enum logic [3:0] {
		S_IDLE, S_ERR_GO, S_DER_GO, S_DER_WAIT,
		S_MP, S_MI, S_MD, S_SUM, S_CL_GO, S_CL_WAIT, S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);

	always_comb begin
		ctrl.cmd = tcpid_pkg::CMD_NONE;
		ctrl.div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (!in_stall && in_valid) begin
					ctrl.cmd = tcpid_pkg::CMD_LOAD;
				end
			end
			S_ERR_GO: ctrl.cmd = tcpid_pkg::CMD_ERR_DIV;
			S_DER_GO: begin
				ctrl.cmd = tcpid_pkg::CMD_DER_DIV;
				ctrl.div_start = 1'b1;
			end
			S_MP: ctrl.cmd = tcpid_pkg::CMD_MUL_P;
			S_MI: ctrl.cmd = tcpid_pkg::CMD_MUL_I;
			S_MD: ctrl.cmd = tcpid_pkg::CMD_MUL_D;
			S_SUM: ctrl.cmd = tcpid_pkg::CMD_SUM_INT;
			S_CL_GO: begin
				ctrl.cmd = tcpid_pkg::CMD_CLAMP_DIV;
				ctrl.div_start = 1'b1;
			end
			S_FIN: ctrl.cmd = tcpid_pkg::CMD_FINISH;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (!in_stall && in_valid) state_q <= S_ERR_GO;
				S_ERR_GO: state_q <= S_DER_GO;
				S_DER_GO: state_q <= S_DER_WAIT;
				S_DER_WAIT: if (!stat.div_busy) state_q <= S_MP;
				S_MP: state_q <= S_MI;
				S_MI: state_q <= S_MD;
				S_MD: state_q <= S_SUM;
				S_SUM: state_q <= stat.gi_zero ? S_FIN : S_CL_GO;
				S_CL_GO: state_q <= S_CL_WAIT;
				S_CL_WAIT: if (!stat.div_busy) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PID_ASSERT_IMP(a_busy_idle, clk, arst_n, state_q == S_IDLE, !stat.div_busy)
	`PID_ASSERT_NXT(a_fin_valid, clk, arst_n, state_q == S_FIN, out_valid_q)
	`PID_ASSERT_IMP(a_no_accept, clk, arst_n, state_q != S_IDLE, in_stall)
endmodule
`default_nettype wire
